// ===== hw/rtl/kpdc_pkg.sv =====
// kpdc_pkg: shared types and constants of the key press duration classifier
// used by kpdc_lane, kpdc_merge and key_press_duration_classifier_unit
// no dependencies

package kpdc_pkg;

  // fixed field widths
  localparam int KEY_W   = 5;
  localparam int KIND_W  = 2;
  localparam int LEVEL_W = 2;
  localparam int CNT8_W  = 8;

  // configuration register indexes (word address bits)
  localparam logic [1:0] REG_PRESS_THR = 2'd0;
  localparam logic [1:0] REG_LONG_THR  = 2'd1;
  localparam logic [1:0] REG_VLONG_THR = 2'd2;
  localparam logic [1:0] REG_COUNT_CAP = 2'd3;

  // configuration reset values
  localparam logic [7:0] PRESS_THR_RST = 8'd2;
  localparam logic [7:0] LONG_THR_RST  = 8'h40;
  localparam logic [7:0] VLONG_THR_RST = 8'haf;
  localparam logic [7:0] COUNT_CAP_RST = 8'hee;

  // event kinds
  localparam logic [1:0] EV_PRESS   = 2'd0;
  localparam logic [1:0] EV_LONG    = 2'd1;
  localparam logic [1:0] EV_VLONG   = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  // release levels
  localparam logic [1:0] LVL_PRESS = 2'd0;
  localparam logic [1:0] LVL_LONG  = 2'd1;
  localparam logic [1:0] LVL_VLONG = 2'd2;

  // fired flag bits
  localparam logic [2:0] FLAG_PRESS = 3'h1;
  localparam logic [2:0] FLAG_LONG  = 3'h2;
  localparam logic [2:0] FLAG_VLONG = 3'h4;

  typedef struct packed {
    logic [7:0] press_thr;
    logic [7:0] long_thr;
    logic [7:0] vlong_thr;
    logic [7:0] count_cap;
  } kpdc_cfg_t;

  // events one key lane raises for the current tick
  typedef struct packed {
    logic [2:0]         thr;    // bit0 press, bit1 long, bit2 very long
    logic               rel;
    logic [LEVEL_W-1:0] level;
  } kpdc_lane_ev_t;

endpackage

// ===== hw/rtl/kpdc_lane.sv =====
// kpdc_lane: one key's hold counter, fired flags and event detection
// depends on kpdc_pkg

module kpdc_lane
  import kpdc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  kpdc_cfg_t     cfg,
  input  logic          step,
  input  logic          level,
  output kpdc_lane_ev_t ev
);

  logic [CNT8_W-1:0] hold_count;
  logic [2:0]        fired_flags;

  logic [CNT8_W-1:0] clamped;
  logic [CNT8_W:0]   inc;
  logic [CNT8_W-1:0] cnt_mid;
  logic              hit;
  logic [2:0]        new_fire;
  logic [2:0]        flags_mid;

  // clamp, increment and saturate for a pressed key
  always_comb begin
    clamped = (hold_count > cfg.count_cap) ? cfg.count_cap : hold_count;
    inc     = {1'b0, clamped} + (CNT8_W+1)'(1);
    if (level) begin
      cnt_mid = hold_count;
    end else if (inc[CNT8_W]) begin
      cnt_mid = '1;
    end else begin
      cnt_mid = inc[CNT8_W-1:0];
    end
  end

  // threshold checks, long and very long nested under press
  always_comb begin
    hit         = cnt_mid > cfg.press_thr;
    new_fire[0] = hit && !fired_flags[0];
    new_fire[1] = hit && (cnt_mid > cfg.long_thr) && !fired_flags[1];
    new_fire[2] = hit && (cnt_mid > cfg.vlong_thr) && !fired_flags[2];
    flags_mid   = fired_flags | new_fire;
  end

  // release event with highest level reached
  always_comb begin
    ev.thr = new_fire;
    ev.rel = level && (flags_mid != '0);
    priority if ((flags_mid & FLAG_VLONG) != '0) begin
      ev.level = LVL_VLONG;
    end else if ((flags_mid & FLAG_LONG) != '0) begin
      ev.level = LVL_LONG;
    end else begin
      ev.level = LVL_PRESS;
    end
  end

  // state update on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count  <= '0;
      fired_flags <= '0;
    end else if (step) begin
      hold_count  <= level ? '0 : cnt_mid;
      fired_flags <= level ? '0 : flags_mid;
    end
  end

endmodule

// ===== hw/rtl/kpdc_merge.sv =====
// kpdc_merge: gathers lane events of a tick, emits up to NUM_KEYS one per cycle while output is ready
// depends on kpdc_pkg

module kpdc_merge
  import kpdc_pkg::*;
#(
  parameter int NUM_KEYS = 23
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      step,
  input  kpdc_lane_ev_t [NUM_KEYS-1:0] lane_ev,
  output logic                      idle,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [15:0]               m_tdata,  // key_index[4:0], event_kind[6:5], level_reached[8:7]
  output logic                      m_tlast   // last_event
);

  localparam int EV_W  = 5 * NUM_KEYS;
  localparam int THR_W = 4 * NUM_KEYS;
  localparam int IDX_W = $clog2(EV_W);
  localparam int KI_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W = $clog2(NUM_KEYS + 1);

  logic [EV_W-1:0]    pend;
  logic [LEVEL_W-1:0] rel_lvl [NUM_KEYS];
  logic [CNT_W-1:0]   cnt;

  logic [EV_W-1:0]    ev_vec;
  logic [IDX_W-1:0]   idx;
  logic [EV_W-1:0]    pend_left;
  logic               load;
  logic               last;
  logic               is_rel;
  logic [KEY_W-1:0]   key;
  logic [KIND_W-1:0]  kind;
  logic [LEVEL_W-1:0] lvl;
  logic [IDX_W-1:0]   rel_off;

  logic [KEY_W-1:0]   out_key;
  logic [KIND_W-1:0]  out_kind;
  logic [LEVEL_W-1:0] out_lvl;

  // event vector: threshold nibbles per key, then release bits per key
  always_comb begin
    ev_vec = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      ev_vec[4*k +: 3]    = lane_ev[k].thr;
      ev_vec[THR_W + k]   = lane_ev[k].rel;
    end
  end

  // lowest pending event
  always_comb begin
    idx = '0;
    for (int i = EV_W - 1; i >= 0; i--) begin
      if (pend[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

  // decode the selected event
  always_comb begin
    is_rel  = idx >= IDX_W'(THR_W);
    rel_off = idx - IDX_W'(THR_W);
    if (is_rel) begin
      key  = KEY_W'(rel_off);
      kind = EV_RELEASE;
      lvl  = rel_lvl[KI_W'(rel_off)];
    end else begin
      key  = KEY_W'(idx[IDX_W-1:2]);
      kind = idx[1:0];
      lvl  = LVL_PRESS;
    end
    pend_left      = pend;
    pend_left[idx] = 1'b0;
    load = (pend != '0) && (!m_tvalid || m_tready);
    last = (pend_left == '0) || (cnt == CNT_W'(NUM_KEYS - 1));
  end

  assign idle = (pend == '0);

  // pending events and emitted count
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cnt  <= '0;
    end else if (step) begin
      pend <= ev_vec;
      cnt  <= '0;
    end else if (load) begin
      pend <= last ? '0 : pend_left;
      cnt  <= cnt + CNT_W'(1);
    end
  end

  // release levels captured with the tick
  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        rel_lvl[k] <= lane_ev[k].level;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_key  <= key;
      out_kind <= kind;
      out_lvl  <= lvl;
      m_tlast  <= last;
    end
  end

  assign m_tdata = {7'd0, out_lvl, out_kind, out_key};

  // a final event empties the pending set
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    load && last |=> pend == '0)
    else $error("pending events left after final event");

  // only release events carry a level
  a_level_rel_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_kind != EV_RELEASE) |-> out_lvl == LVL_PRESS)
    else $error("level on non-release event");

  // key index stays in range
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_key < KEY_W'(NUM_KEYS))
    else $error("key index out of range");

  // no more than NUM_KEYS events per tick
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    pend != '0 |-> cnt <= CNT_W'(NUM_KEYS - 1))
    else $error("event count overrun");

endmodule

// ===== hw/rtl/key_press_duration_classifier_unit.sv =====
// key_press_duration_classifier_unit: top level with register port and key lanes
// depends on kpdc_pkg, kpdc_lane and kpdc_merge

// One scan tick (an item of key levels, 0 = pressed) is taken when no events of
// the previous tick are still pending. All keys are updated in parallel lanes in
// the accept cycle; the merge stage then emits the tick's events one per cycle
// while the output side is ready, threshold events (press, long, very long) for
// keys from 0 up, then release events from key 0 up, at most NUM_KEYS per tick,
// tlast on the final one. A tick keeps the block busy until its final event has
// been loaded into the output register, so output stalls hold the next tick off.
// Registers: 0x0 press threshold, 0x4 long threshold, 0x8 very long threshold,
// 0xC count cap, 8 bits each; write only while the block is idle.

module key_press_duration_classifier_unit
  import kpdc_pkg::*;
#(
  parameter int NUM_KEYS = 23
) (
  input  logic                              clk,
  input  logic                              rst,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  // scan ticks
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [((NUM_KEYS+7)/8)*8-1:0]     s_tdata,  // key_levels[NUM_KEYS-1:0]
  // events
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // key_index[4:0], event_kind[6:5], level_reached[8:7]
  output logic                              m_tlast   // last_event
);

  kpdc_cfg_t                     cfg;
  kpdc_lane_ev_t [NUM_KEYS-1:0]  lane_ev;
  logic                          step;
  logic                          idle;
  logic                          wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_thr <= PRESS_THR_RST;
      cfg.long_thr  <= LONG_THR_RST;
      cfg.vlong_thr <= VLONG_THR_RST;
      cfg.count_cap <= COUNT_CAP_RST;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_PRESS_THR: cfg.press_thr <= pwdata[7:0];
        REG_LONG_THR:  cfg.long_thr  <= pwdata[7:0];
        REG_VLONG_THR: cfg.vlong_thr <= pwdata[7:0];
        REG_COUNT_CAP: cfg.count_cap <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[3:2])
      REG_PRESS_THR: prdata = {24'd0, cfg.press_thr};
      REG_LONG_THR:  prdata = {24'd0, cfg.long_thr};
      REG_VLONG_THR: prdata = {24'd0, cfg.vlong_thr};
      REG_COUNT_CAP: prdata = {24'd0, cfg.count_cap};
      default:       prdata = '0;
    endcase
  end

  // tick accept
  assign s_tready = idle;
  assign step     = s_tvalid && s_tready;

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kpdc_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .cfg   (cfg),
      .step  (step),
      .level (s_tdata[k]),
      .ev    (lane_ev[k])
    );
  end

  // event serialiser
  kpdc_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .lane_ev  (lane_ev),
    .idle     (idle),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
